FILE: hw/rtl/sfcc_pkg.sv
// Shared types, constants and the CRC step function for the frame checker.
`timescale 1ns / 1ps
`default_nettype none
package sfcc_pkg;

   // Byte position counter width (payload up to 65535 plus header and CRC)
   localparam int unsigned CNT_W = 17;

   // Frame layout positions
   localparam logic [CNT_W-1:0] POS_SYNC0    = 17'd0;
   localparam logic [CNT_W-1:0] POS_SYNC1    = 17'd1;
   localparam logic [CNT_W-1:0] POS_VERSION  = 17'd2;
   localparam logic [CNT_W-1:0] POS_TYPE     = 17'd3;
   localparam logic [CNT_W-1:0] POS_SEQ_HI   = 17'd4;
   localparam logic [CNT_W-1:0] POS_SEQ_LO   = 17'd5;
   localparam logic [CNT_W-1:0] POS_LEN_HI   = 17'd6;
   localparam logic [CNT_W-1:0] POS_LEN_LO   = 17'd7;
   localparam logic [CNT_W-1:0] HEADER_BYTES = 17'd8;
   // Position of the tenth byte, where header faults are reported
   localparam logic [CNT_W-1:0] POS_CHECK    = 17'd9;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_EXP_VERSION = 2'd2;
   localparam logic [1:0] CSR_MAX_LEN     = 2'd3;

   // Register reset values
   localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
   localparam logic [7:0]  EXP_VERSION_RST = 8'h01;
   localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

   // Header fault codes
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_VERSION = 2'd1;
   localparam logic [1:0] FAULT_LENGTH  = 2'd2;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Frame status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NEED_MORE = 3'd1;
   localparam logic [2:0] ST_SYNC      = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_LENGTH    = 3'd4;
   localparam logic [2:0] ST_CRC       = 3'd5;

   // One result beat
   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [7:0]  frame_version;
      logic [7:0]  frame_type;
      logic [15:0] frame_seq;
      logic [15:0] frame_length;
      logic [15:0] frame_crc;
   } rsp_type;

   // CRC-16/CCITT-FALSE update by one byte, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sync_frame_crc_checker.sv
// Sync-header frame parser with CRC-16/CCITT-FALSE check, one byte per beat.
// A result beat is registered in the output buffer before it shows on rsp_valid.
// Throughput: one byte per cycle while req_ready is high; the frame state updates once per accepted byte.
// A two-entry output buffer lets bytes keep coming while one result waits.
// Reset (synchronous, active high) restores register defaults and clears the frame.
`timescale 1ns / 1ps
`default_nettype none
module sync_frame_crc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_in_buffer,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_out_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_frame_version,
   output logic [7:0]       rsp_frame_type,
   output logic [15:0]      rsp_frame_seq,
   output logic [15:0]      rsp_frame_length,
   output logic [15:0]      rsp_frame_crc,
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // Configuration registers
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [7:0]  exp_version_ff;
   logic [15:0] max_len_ff;

   // Frame state
   logic [sfcc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  ver_ff, ver_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [1:0]  hfault_ff, hfault_in;
   logic        sfault_ff, sfault_in;
   logic        given_ff, given_in;

   // Output buffer: head plus one skid entry
   sfcc_pkg::rsp_type head_ff, head_in, skid_ff, skid_in;
   logic              head_v_ff, head_v_in, skid_v_ff, skid_v_in;

   logic                       accept;
   logic                       res_valid;
   sfcc_pkg::rsp_type          res;
   logic                       fault;
   logic [sfcc_pkg::CNT_W-1:0] len_p8;
   logic [sfcc_pkg::CNT_W-1:0] len_p9;
   logic [15:0]                rx_crc;
   logic [15:0]                new_len;
   logic                       pop;

   assign accept    = req_valid && req_ready;
   assign req_ready = !skid_v_ff;
   assign pop       = head_v_ff && rsp_ready;

   // Configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= sfcc_pkg::SYNC_FIRST_RST;
         sync_second_ff <= sfcc_pkg::SYNC_SECOND_RST;
         exp_version_ff <= sfcc_pkg::EXP_VERSION_RST;
         max_len_ff     <= sfcc_pkg::MAX_LEN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfcc_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            sfcc_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            sfcc_pkg::CSR_EXP_VERSION: exp_version_ff <= csr_wdata[7:0];
            sfcc_pkg::CSR_MAX_LEN:     max_len_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign len_p8 = {1'b0, len_ff} + sfcc_pkg::HEADER_BYTES;
   assign len_p9 = {1'b0, len_ff} + sfcc_pkg::POS_CHECK;
   assign rx_crc = {crc_hi_ff, req_data_byte};
   assign new_len = {len_ff[15:8], req_data_byte};

   // Per-byte frame parse
   always_comb begin
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      ver_in    = ver_ff;
      type_in   = type_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      crc_hi_in = crc_hi_ff;
      hfault_in = hfault_ff;
      sfault_in = sfault_ff;
      given_in  = given_ff;
      res_valid = 1'b0;
      res       = '0;
      fault     = 1'b0;

      if (accept && !given_ff) begin
         // sync bytes
         if ((cnt_ff == sfcc_pkg::POS_SYNC0 && req_data_byte != sync_first_ff) ||
             (cnt_ff == sfcc_pkg::POS_SYNC1 && req_data_byte != sync_second_ff)) begin
            sfault_in = 1'b1;
         end

         // CRC covers version byte through last payload byte
         if ((cnt_ff >= sfcc_pkg::POS_VERSION && cnt_ff < sfcc_pkg::HEADER_BYTES) ||
             (cnt_ff >= sfcc_pkg::HEADER_BYTES && cnt_ff < len_p8)) begin
            crc_in = sfcc_pkg::crc16_byte(crc_ff, req_data_byte);
         end

         // header field capture
         case (cnt_ff)
            sfcc_pkg::POS_VERSION: begin
               ver_in = req_data_byte;
               if (req_data_byte != exp_version_ff) begin
                  hfault_in = sfcc_pkg::FAULT_VERSION;
               end
            end
            sfcc_pkg::POS_TYPE:   type_in = req_data_byte;
            sfcc_pkg::POS_SEQ_HI: seq_in  = {req_data_byte, 8'h00};
            sfcc_pkg::POS_SEQ_LO: seq_in  = {seq_ff[15:8], req_data_byte};
            sfcc_pkg::POS_LEN_HI: len_in  = {req_data_byte, 8'h00};
            sfcc_pkg::POS_LEN_LO: begin
               len_in = new_len;
               if (hfault_ff == sfcc_pkg::FAULT_NONE && new_len > max_len_ff) begin
                  hfault_in = sfcc_pkg::FAULT_LENGTH;
               end
            end
            default: ;
         endcase

         fault = sfault_in || (hfault_in != sfcc_pkg::FAULT_NONE);

         // high CRC byte follows the payload
         if (cnt_ff >= sfcc_pkg::HEADER_BYTES && cnt_ff == len_p8) begin
            crc_hi_in = req_data_byte;
         end

         // result selection
         if (cnt_ff < sfcc_pkg::POS_CHECK) begin
            if (req_last_in_buffer) begin
               res_valid  = 1'b1;
               res.out_kind = sfcc_pkg::KIND_STATUS;
               res.status = sfcc_pkg::ST_NEED_MORE;
            end else if (cnt_ff == sfcc_pkg::HEADER_BYTES && !fault && len_ff != 16'd0) begin
               res_valid = 1'b1;
               res.out_kind = sfcc_pkg::KIND_PAYLOAD;
               res.payload_byte = req_data_byte;
            end
         end else if (cnt_ff == sfcc_pkg::POS_CHECK && fault) begin
            res_valid = 1'b1;
            res.out_kind = sfcc_pkg::KIND_STATUS;
            if (sfault_in) begin
               res.status = sfcc_pkg::ST_SYNC;
            end else if (hfault_in == sfcc_pkg::FAULT_VERSION) begin
               res.status = sfcc_pkg::ST_VERSION;
            end else begin
               res.status = sfcc_pkg::ST_LENGTH;
            end
         end else if (cnt_ff == len_p9) begin
            res_valid = 1'b1;
            res.out_kind = sfcc_pkg::KIND_STATUS;
            res.frame_seq = seq_ff;
            if (rx_crc == crc_ff) begin
               res.status        = sfcc_pkg::ST_OK;
               res.frame_version = ver_ff;
               res.frame_type    = type_ff;
               res.frame_length  = len_ff;
               res.frame_crc     = rx_crc;
            end else begin
               res.status = sfcc_pkg::ST_CRC;
            end
         end else if (req_last_in_buffer) begin
            res_valid = 1'b1;
            res.out_kind = sfcc_pkg::KIND_STATUS;
            res.status = sfcc_pkg::ST_NEED_MORE;
         end else if (cnt_ff < len_p8) begin
            res_valid = 1'b1;
            res.out_kind = sfcc_pkg::KIND_PAYLOAD;
            res.payload_byte = req_data_byte;
         end

         // a status beat freezes the frame until the buffer ends
         if (res_valid && res.out_kind == sfcc_pkg::KIND_STATUS) begin
            given_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 17'd1;
         end
      end

      // buffer end restarts parsing
      if (accept && req_last_in_buffer) begin
         cnt_in    = '0;
         crc_in    = sfcc_pkg::CRC_INIT;
         ver_in    = '0;
         type_in   = '0;
         seq_in    = '0;
         len_in    = '0;
         crc_hi_in = '0;
         hfault_in = sfcc_pkg::FAULT_NONE;
         sfault_in = 1'b0;
         given_in  = 1'b0;
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         crc_ff    <= sfcc_pkg::CRC_INIT;
         ver_ff    <= '0;
         type_ff   <= '0;
         seq_ff    <= '0;
         len_ff    <= '0;
         crc_hi_ff <= '0;
         hfault_ff <= sfcc_pkg::FAULT_NONE;
         sfault_ff <= 1'b0;
         given_ff  <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         ver_ff    <= ver_in;
         type_ff   <= type_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         crc_hi_ff <= crc_hi_in;
         hfault_ff <= hfault_in;
         sfault_ff <= sfault_in;
         given_ff  <= given_in;
      end
   end

   // Output buffer next state
   always_comb begin
      head_in   = head_ff;
      skid_in   = skid_ff;
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            skid_v_in = res_valid;
            skid_in   = res;
         end else begin
            head_v_in = res_valid;
            head_in   = res;
         end
      end else if (res_valid) begin
         if (!head_v_ff) begin
            head_in   = res;
            head_v_in = 1'b1;
         end else begin
            skid_in   = res;
            skid_v_in = 1'b1;
         end
      end
   end

   // Output buffer valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // Output buffer payload
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = head_v_ff;
   assign rsp_out_kind      = head_ff.out_kind;
   assign rsp_payload_byte  = head_ff.payload_byte;
   assign rsp_status        = head_ff.status;
   assign rsp_frame_version = head_ff.frame_version;
   assign rsp_frame_type    = head_ff.frame_type;
   assign rsp_frame_seq     = head_ff.frame_seq;
   assign rsp_frame_length  = head_ff.frame_length;
   assign rsp_frame_crc     = head_ff.frame_crc;

endmodule
`default_nettype wire
